// File: sv/fsd_pkg.sv
package fsd_pkg;
  localparam int unsigned TableEntriesDefault = 1024;
  localparam int unsigned KeyW  = 96;
  localparam int unsigned RttW  = 29;
  localparam int unsigned SumW  = 33;
  localparam int unsigned MultW = 16;
  localparam int unsigned DefaultMult = 3;
  localparam int unsigned EmaKeep = 9;
  localparam int unsigned EmaDiv = 10;
  localparam int unsigned InDataW = 192;
  localparam int unsigned OutDataW = 192;
  localparam int unsigned CfgIdxW = 8;

  // The quotient by ten is the product with ceil(2^36 / 10), shifted right by 36; this is
  // exact for every dividend below 2^34.
  localparam int unsigned RecipW = 33;
  localparam logic [RecipW-1:0] DivRecip = 33'h1_9999_999A;
  localparam int unsigned RecipShift = 36;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET_PORT = 8'd0,
    REG_SPIKE_MULT  = 8'd1
  } reg_idx_e;

  typedef struct packed {
    logic            start;
    logic [SumW-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [RttW-1:0] quotient;
  } div_rsp_t;
endpackage

// File: sv/fsd_div10.sv
module fsd_div10 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsd_pkg::div_req_t req_i,
  output fsd_pkg::div_rsp_t rsp_o
);
  import fsd_pkg::*;

  localparam int unsigned LoW     = 17;
  localparam int unsigned LoProdW = SumW + LoW;
  localparam int unsigned HiProdW = SumW + RecipW - LoW;
  localparam int unsigned ProdW   = HiProdW + LoW;

  logic [LoProdW-1:0] lo_d, lo_q;
  logic [HiProdW-1:0] hi_d, hi_q;
  logic [ProdW-1:0]   prod;
  logic [RttW-1:0]    quot_d, quot_q;
  logic               stage_q;
  logic               done_q;

  assign lo_d   = LoProdW'(req_i.dividend) * LoProdW'(DivRecip[LoW-1:0]);
  assign hi_d   = HiProdW'(req_i.dividend) * HiProdW'(DivRecip[RecipW-1:LoW]);
  assign prod   = {hi_q, {LoW{1'b0}}} + ProdW'(lo_q);
  assign quot_d = prod[RecipShift +: RttW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= req_i.start;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (stage_q) begin
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;
endmodule

// File: sv/fsd_table.sv
module fsd_table #(
  parameter int unsigned TABLE_ENTRIES = fsd_pkg::TableEntriesDefault,
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [IdxW-1:0]                       rd_addr_i,
  output logic [fsd_pkg::KeyW+fsd_pkg::RttW-1:0] rd_data_o,
  input  logic                                  wr_en_i,
  input  logic [IdxW-1:0]                       wr_addr_i,
  input  logic [fsd_pkg::KeyW+fsd_pkg::RttW-1:0] wr_data_i
);
  import fsd_pkg::*;

  logic [KeyW+RttW-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end
endmodule

// File: sv/flow_rtt_spike_detector.sv
// A request is accepted only in idle; an ignored one, or the first on an empty table,
// frees the input again after the accepting cycle. Otherwise the table is probed entry by entry
// in ST_RD and ST_CMP; a miss appends the key if there is room, and a hit runs ST_MUL, ST_UPD
// and ST_DIV, a reciprocal divide by ten. A spike also waits while the previous result is held.
// Reset is asynchronous and active low; it clears the config registers, control and fill count.
// The table contents need no clearing, since only entries below the fill count are read.
module flow_rtt_spike_detector #(
  parameter int unsigned TABLE_ENTRIES = fsd_pkg::TableEntriesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // src_addr, dst_addr, src_port, dst_port, srtt_scaled, time_ns
  input  logic [fsd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // ev_src_addr, ev_dst_addr, ev_src_port, ev_dst_port, spike_rtt_us, ev_time_ns, zero pad
  output logic [fsd_pkg::OutDataW-1:0]   m_axis_tdata
);
  import fsd_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ThrW = RttW + MultW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DIV  = 6'b100000
  } state_e;

  state_e state_d, state_q;
  logic [15:0] tport_q, mult_q;
  logic [CntW-1:0] held_d, held_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic [KeyW-1:0] key_q;
  logic [RttW-1:0] rtt_q, base_q;
  logic [63:0] time_q;
  logic [ThrW-1:0] thr_q;
  logic out_valid_d, out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic load_out;

  logic [KeyW-1:0] in_key;
  logic [RttW-1:0] in_rtt;
  logic in_take, in_ignore;

  logic rd_en, wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [KeyW+RttW-1:0] rd_data, wr_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take = s_axis_tvalid && s_axis_tready;
  assign in_key = s_axis_tdata[95:0];
  assign in_rtt = s_axis_tdata[127:99];
  assign in_ignore = (tport_q == 16'd0) || (s_axis_tdata[95:80] != tport_q) ||
                     (in_rtt == '0);

  always_comb begin
    state_d = state_q;
    held_d = held_q;
    idx_d = idx_q;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_addr = idx_q;
    wr_data = {key_q, div_rsp.quotient};
    div_req.start = 1'b0;
    div_req.dividend = SumW'({base_q, 3'b000}) + SumW'(base_q) + SumW'(rtt_q);
    out_valid_d = out_valid_q && !m_axis_tready;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take && !in_ignore) begin
          if (held_q == '0) begin
            wr_en = 1'b1;
            wr_addr = '0;
            wr_data = {in_key, in_rtt};
            held_d = CntW'(1);
          end else begin
            idx_d = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (rd_data[KeyW+RttW-1:RttW] == key_q) begin
          state_d = ST_MUL;
        end else if (CntW'(idx_q) + CntW'(1) == held_q) begin
          if (held_q < CntW'(TABLE_ENTRIES)) begin
            wr_en = 1'b1;
            wr_addr = IdxW'(held_q);
            wr_data = {key_q, rtt_q};
            held_d = held_q + CntW'(1);
          end
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
          state_d = ST_RD;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (ThrW'(rtt_q) > thr_q) begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d = 1'b1;
            load_out = 1'b1;
            div_req.start = 1'b1;
            state_d = ST_DIV;
          end
        end else begin
          div_req.start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          wr_en = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      held_q <= '0;
      tport_q <= '0;
      mult_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_TARGET_PORT: tport_q <= cfg_data_i;
          REG_SPIKE_MULT:  mult_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (in_take) begin
      key_q <= in_key;
      rtt_q <= in_rtt;
      time_q <= s_axis_tdata[191:128];
    end
    if (state_q == ST_CMP) begin
      base_q <= rd_data[RttW-1:0];
    end
    if (state_q == ST_MUL) begin
      thr_q <= ThrW'(base_q) * ThrW'((mult_q == 16'd0) ? 16'(DefaultMult) : mult_q);
    end
    if (load_out) begin
      out_data_q <= {3'b000, time_q, rtt_q, key_q};
    end
  end

  fsd_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  fsd_div10 u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(TABLE_ENTRIES)) else $error("fill count beyond table size");
  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (held_q == $past(held_q)) || (held_q == $past(held_q) + CntW'(1)))
    else $error("fill count jumped");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPD)) else $error("result without hit");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV) else $error("divider finished out of turn");
endmodule
